/* hw/rtl/optimal_merge_cost_defines.svh */
// assertion macros shared by the rtl files
`ifndef OPTIMAL_MERGE_COST_DEFINES_SVH
`define OPTIMAL_MERGE_COST_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define OMC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
// condition must never be seen outside reset
`define OMC_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition seen");
`else
`define OMC_ASSERT(lbl, prop)
`define OMC_NEVER(lbl, cond)
`endif

`endif

/* hw/rtl/omc_pkg.sv */
package omc_pkg;

   // field widths
   localparam int LEN_W   = 16;
   localparam int STORE_W = 20;
   localparam int COST_W  = 24;

   // default capacity of the piece store
   localparam int MAX_PIECES_DEF = 16;

   // controller to datapath
   typedef struct packed {
      logic load;     // request accepted this cycle
      logic scan_en;  // walk the store looking for the two minima
      logic write_a;  // store the merge sum over the smallest entry
      logic write_b;  // move the last entry, or the merge sum if it sat there, into the second slot
      logic finish;   // load the result register and clear the set
   } omc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_nonzero; // at least one piece already stored
      logic scan_done;     // final entry of the scan compared this cycle
      logic n_gt2;         // more than one value left after this merge
      logic rsp_free;      // result register can take a new result
   } omc_status_type;

endpackage

/* hw/rtl/omc_datapath.sv */
`include "optimal_merge_cost_defines.svh"

module omc_datapath #(
   parameter int MAX_PIECES = omc_pkg::MAX_PIECES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  omc_pkg::omc_cmd_type        cmd,
   output omc_pkg::omc_status_type     status,
   input  logic [omc_pkg::LEN_W-1:0]   req_piece_length,
   input  logic                        req_last_piece,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [omc_pkg::COST_W-1:0]  rsp_total_cost,
   output logic                        rsp_dropped_pieces
);
   import omc_pkg::*;

   localparam int CNT_W = $clog2(MAX_PIECES + 1);
   localparam int IDX_W = $clog2(MAX_PIECES);

   // piece store
   logic [STORE_W-1:0] mem [MAX_PIECES];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               ovf_ff, ovf_in;
   logic [COST_W-1:0]  cost_ff, cost_in;
   logic [CNT_W-1:0]   scan_addr_ff, scan_addr_in;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [STORE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   a_idx_ff, a_idx_in, b_idx_ff, b_idx_in;
   logic [STORE_W-1:0] a_val_ff, a_val_in, b_val_ff, b_val_in;
   logic [STORE_W-1:0] last_val_ff, last_val_in;
   logic [STORE_W-1:0] sum_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]  rsp_cost_ff;
   logic               rsp_drop_ff;

   logic               room;
   logic               issue;
   logic [IDX_W-1:0]   n_last;
   logic [STORE_W:0]   sum_wide;
   logic [STORE_W-1:0] sum_sat;
   logic [COST_W:0]    cost_wide;
   logic [COST_W-1:0]  cost_sat;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [STORE_W-1:0] wr_data;

   assign room   = count_ff < CNT_W'(MAX_PIECES);
   assign issue  = cmd.scan_en && (scan_addr_ff < n_ff);
   assign n_last = IDX_W'(n_ff - 1'b1);

   // saturating merge sum and cost
   assign sum_wide  = {1'b0, a_val_ff} + {1'b0, b_val_ff};
   assign sum_sat   = sum_wide[STORE_W] ? {STORE_W{1'b1}} : sum_wide[STORE_W-1:0];
   assign cost_wide = {1'b0, cost_ff} + (COST_W + 1)'(sum_sat);
   assign cost_sat  = cost_wide[COST_W] ? {COST_W{1'b1}} : cost_wide[COST_W-1:0];

   // store write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = a_idx_ff;
      wr_data = sum_sat;
      if (cmd.load && room) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = STORE_W'(req_piece_length);
      end else if (cmd.write_a) begin
         wr_en   = 1'b1;
      end else if (cmd.write_b) begin
         wr_en   = 1'b1;
         wr_addr = b_idx_ff;
         wr_data = (a_idx_ff == n_last) ? sum_ff : last_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[scan_addr_ff[IDX_W-1:0]];
   end

   // set bookkeeping, scan and result
   always_comb begin
      count_in     = count_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      cost_in      = cost_ff;
      scan_addr_in = scan_addr_ff;
      a_idx_in     = a_idx_ff;
      a_val_in     = a_val_ff;
      b_idx_in     = b_idx_ff;
      b_val_in     = b_val_ff;
      last_val_in  = last_val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // accept a piece
      if (cmd.load) begin
         scan_addr_in = '0;
         if (room) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (req_last_piece) begin
            n_in = room ? count_ff + 1'b1 : count_ff;
         end
      end

      // read address walk
      if (issue) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end

      // running two-smallest search, strict compares keep the earlier index
      if (rd_valid_ff) begin
         if (rd_idx_ff == '0) begin
            a_idx_in = rd_idx_ff;
            a_val_in = rd_data_ff;
         end else if (rd_data_ff < a_val_ff) begin
            b_idx_in = a_idx_ff;
            b_val_in = a_val_ff;
            a_idx_in = rd_idx_ff;
            a_val_in = rd_data_ff;
         end else if ((rd_idx_ff == IDX_W'(1)) || (rd_data_ff < b_val_ff)) begin
            b_idx_in = rd_idx_ff;
            b_val_in = rd_data_ff;
         end
         if (rd_idx_ff == n_last) begin
            last_val_in = rd_data_ff;
         end
      end

      // merge step
      if (cmd.write_a) begin
         cost_in = cost_sat;
      end
      if (cmd.write_b) begin
         n_in         = n_ff - 1'b1;
         scan_addr_in = '0;
      end

      // hand over the result and clear the set
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         count_in     = '0;
         ovf_in       = 1'b0;
         cost_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         cost_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         cost_ff      <= cost_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= scan_addr_ff[IDX_W-1:0];
      a_idx_ff     <= a_idx_in;
      a_val_ff     <= a_val_in;
      b_idx_ff     <= b_idx_in;
      b_val_ff     <= b_val_in;
      last_val_ff  <= last_val_in;
      if (cmd.write_a) begin
         sum_ff <= sum_sat;
      end
      if (cmd.finish) begin
         rsp_cost_ff <= cost_ff;
         rsp_drop_ff <= ovf_ff;
      end
   end

   // status back to the controller
   assign status.count_nonzero = count_ff != '0;
   assign status.scan_done     = rd_valid_ff && (rd_idx_ff == n_last);
   assign status.n_gt2         = n_ff > CNT_W'(2);
   assign status.rsp_free      = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_cost     = rsp_cost_ff;
   assign rsp_dropped_pieces = rsp_drop_ff;

   // checks
   `OMC_NEVER(a_count_range, count_ff > CNT_W'(MAX_PIECES))
   `OMC_ASSERT(a_pair_distinct, cmd.write_a |-> (a_idx_ff != b_idx_ff))
   `OMC_ASSERT(a_merge_shrinks, cmd.write_b |=> (n_ff == $past(n_ff) - 1'b1))
endmodule

/* hw/rtl/omc_ctrl.sv */
`include "optimal_merge_cost_defines.svh"

module omc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last_piece,
   output logic                     req_stall,
   output omc_pkg::omc_cmd_type     cmd,
   input  omc_pkg::omc_status_type  status
);
   import omc_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_WRITE_A,
      ST_WRITE_B,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = state_ff != ST_LOAD;
   assign accept    = req_valid && !req_stall;

   // commands
   assign cmd.load    = accept;
   assign cmd.scan_en = state_ff == ST_SCAN;
   assign cmd.write_a = state_ff == ST_WRITE_A;
   assign cmd.write_b = state_ff == ST_WRITE_B;
   assign cmd.finish  = (state_ff == ST_RESULT) && status.rsp_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_piece) begin
               state_in = status.count_nonzero ? ST_SCAN : ST_RESULT;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_WRITE_A;
            end
         end
         ST_WRITE_A: begin
            state_in = ST_WRITE_B;
         end
         ST_WRITE_B: begin
            state_in = status.n_gt2 ? ST_SCAN : ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `OMC_ASSERT(a_write_pair, (state_ff == ST_WRITE_A) |=> (state_ff == ST_WRITE_B))
   `OMC_ASSERT(a_done_in_scan, status.scan_done |-> (state_ff == ST_SCAN))
   `OMC_NEVER(a_load_in_merge, cmd.load && (cmd.write_a || cmd.write_b || cmd.scan_en))
endmodule

/* hw/rtl/optimal_merge_cost.sv */
// channel     direction  handshake               payload
// req         in         req_valid / req_stall   req_piece_length, req_last_piece
// rsp         out        rsp_valid / rsp_stall   rsp_total_cost, rsp_dropped_pieces
//
// pieces load one per cycle while req_stall is low; each merge scans the store
// for the two smallest values, then writes back in two steps, write a and write b,
// and a final result step registers the total cost
// requests are stalled from the final piece until its result is registered
// rsp_stall holds the result register; the next set loads while it waits
// synchronous active-high reset; the store needs no clearing
module optimal_merge_cost #(
   parameter int MAX_PIECES = omc_pkg::MAX_PIECES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [omc_pkg::LEN_W-1:0]   req_piece_length,
   input  logic                        req_last_piece,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [omc_pkg::COST_W-1:0]  rsp_total_cost,
   output logic                        rsp_dropped_pieces
);
   import omc_pkg::*;

   omc_cmd_type    cmd;
   omc_status_type status;

   // sequencer
   omc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_piece (req_last_piece),
      .req_stall      (req_stall),
      .cmd            (cmd),
      .status         (status)
   );

   // store, minimum search and accumulator
   omc_datapath #(
      .MAX_PIECES (MAX_PIECES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_piece_length   (req_piece_length),
      .req_last_piece     (req_last_piece),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_cost     (rsp_total_cost),
      .rsp_dropped_pieces (rsp_dropped_pieces)
   );
endmodule

/* sim/optimal_merge_cost_checker.sv */
module optimal_merge_cost_checker #(
   parameter int CAPACITY = omc_pkg::MAX_PIECES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [omc_pkg::LEN_W-1:0]  req_piece_length,
   input  logic                       req_last_piece,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [omc_pkg::COST_W-1:0] rsp_total_cost,
   input  logic                       rsp_dropped_pieces,
   output int                         mismatch_count,
   output int                         results_waiting,
   output int                         results_checked
);
   import omc_pkg::*;

   localparam int               IDX_W     = $clog2(CAPACITY);
   localparam logic [STORE_W:0] STORE_SAT = (STORE_W + 1)'((1 << STORE_W) - 1);
   localparam logic [COST_W:0]  COST_SAT  = (COST_W + 1)'((1 << COST_W) - 1);

   typedef struct packed {
      logic [COST_W-1:0] total_cost;
      logic              dropped_pieces;
   } merge_result_type;

   logic [STORE_W-1:0] length_store [CAPACITY];
   int                 stored_count;
   logic               drop_seen;
   int                 fail_total;
   int                 checked_total;
   merge_result_type   cost_queue [$];

   // greedy merge of the stored lengths, two smallest first, saturating sums
   task automatic merge_set(output logic [COST_W-1:0] cost);
      int               n;
      int               lo;
      int               next;
      int               i;
      logic [STORE_W:0] pair_sum;
      logic [COST_W:0]  running;
      n = stored_count;
      running = '0;
      while (n > 1) begin
         lo = (length_store[IDX_W'(1)] < length_store[IDX_W'(0)]) ? 1 : 0;
         next = 1 - lo;
         for (i = 2; i < n; i++) begin
            if (length_store[IDX_W'(i)] < length_store[IDX_W'(lo)]) begin
               next = lo;
               lo = i;
            end else if (length_store[IDX_W'(i)] < length_store[IDX_W'(next)]) begin
               next = i;
            end
         end
         pair_sum = {1'b0, length_store[IDX_W'(lo)]} + {1'b0, length_store[IDX_W'(next)]};
         if (pair_sum > STORE_SAT) pair_sum = STORE_SAT;
         running = running + (COST_W + 1)'(pair_sum);
         if (running > COST_SAT) running = COST_SAT;
         length_store[IDX_W'(lo)] = pair_sum[STORE_W-1:0];
         length_store[IDX_W'(next)] = length_store[IDX_W'(n - 1)];
         n--;
      end
      cost = running[COST_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      merge_result_type  expected;
      logic [COST_W-1:0] cost;
      if (reset) begin
         stored_count = 0;
         drop_seen = 1'b0;
         fail_total = 0;
         checked_total = 0;
         cost_queue.delete();
      end else begin
         // accepted request: store the piece or note the drop
         if (req_valid && !req_stall) begin
            if (stored_count < CAPACITY) begin
               length_store[IDX_W'(stored_count)] = STORE_W'(req_piece_length);
               stored_count++;
            end else begin
               drop_seen = 1'b1;
            end
            // final piece closes the set and predicts its cost
            if (req_last_piece) begin
               merge_set(cost);
               expected.total_cost = cost;
               expected.dropped_pieces = drop_seen;
               cost_queue.push_back(expected);
               stored_count = 0;
               drop_seen = 1'b0;
            end
         end
         // accepted result against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (cost_queue.size() == 0) begin
               $error("result with no set pending: total_cost %0d dropped_pieces %0b",
                      rsp_total_cost, rsp_dropped_pieces);
               fail_total++;
            end else begin
               expected = cost_queue.pop_front();
               checked_total++;
               if (rsp_total_cost !== expected.total_cost) begin
                  $error("total_cost mismatch: expected %0d, actual %0d",
                         expected.total_cost, rsp_total_cost);
                  fail_total++;
               end
               if (rsp_dropped_pieces !== expected.dropped_pieces) begin
                  $error("dropped_pieces mismatch: expected %0b, actual %0b",
                         expected.dropped_pieces, rsp_dropped_pieces);
                  fail_total++;
               end
            end
         end
      end
      mismatch_count <= fail_total;
      results_checked <= checked_total;
      results_waiting <= cost_queue.size();
   end

endmodule

/* sim/optimal_merge_cost_tb.sv */
module optimal_merge_cost_tb;
   import omc_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int DIRECTED_ITEMS = 24;
   localparam int RANDOM_ITEMS   = 900;

   typedef enum int {LEN_ANY, LEN_SMALL, LEN_EXTREME, LEN_EQUAL} length_style_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [LEN_W-1:0]  req_piece_length;
   logic              req_last_piece;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [COST_W-1:0] rsp_total_cost;
   logic              rsp_dropped_pieces;

   int mismatch_count;
   int results_waiting;
   int results_checked;
   int send_gap_pct;
   int stall_pct;
   int pieces_sent;
   int sets_sent;
   int overfilled_sets;
   int set_fill;
   int cycle_count;

   optimal_merge_cost u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_piece_length   (req_piece_length),
      .req_last_piece     (req_last_piece),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_cost     (rsp_total_cost),
      .rsp_dropped_pieces (rsp_dropped_pieces)
   );

   optimal_merge_cost_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_piece_length   (req_piece_length),
      .req_last_piece     (req_last_piece),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_cost     (rsp_total_cost),
      .rsp_dropped_pieces (rsp_dropped_pieces),
      .mismatch_count     (mismatch_count),
      .results_waiting    (results_waiting),
      .results_checked    (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stalls at random, rate set by the current phase
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // run guard
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
   end

   // one request, with random idle cycles ahead of it
   task automatic send_piece(input logic [LEN_W-1:0] len, input logic last);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_piece_length <= len;
      req_last_piece <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pieces_sent++;
      set_fill++;
      if (last) begin
         sets_sent++;
         if (set_fill > MAX_PIECES_DEF) overfilled_sets++;
         set_fill = 0;
      end
   endtask

   function automatic logic [LEN_W-1:0] pick_length(input length_style_type style);
      logic [LEN_W-1:0] len;
      len = LEN_W'($urandom);
      case (style)
         LEN_SMALL: len = LEN_W'($urandom_range(0, 15));
         LEN_EXTREME: begin
            case ($urandom_range(0, 2))
               0: len = '0;
               1: len = '1;
               default: len = LEN_W'($urandom);
            endcase
         end
         default: ;
      endcase
      return len;
   endfunction

   task automatic send_set(input int pieces, input length_style_type style);
      logic [LEN_W-1:0] shared;
      int               k;
      shared = LEN_W'($urandom);
      for (k = 0; k < pieces; k++) begin
         send_piece((style == LEN_EQUAL) ? shared : pick_length(style), k == pieces - 1);
      end
   endtask

   initial begin : stimulus
      int               size;
      int               k;
      length_style_type style;
      reset = 1'b1;
      req_valid = 1'b0;
      req_piece_length = '0;
      req_last_piece = 1'b0;
      send_gap_pct = 7;
      stall_pct = 47;
      pieces_sent = 0;
      sets_sent = 0;
      overfilled_sets = 0;
      set_fill = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single largest piece: cost zero
      send_piece('1, 1'b1);
      // two zero pieces
      send_piece('0, 1'b0);
      send_piece('0, 1'b1);
      // equal values
      for (k = 0; k < 3; k++) send_piece(16'd7, k == 2);
      // full store of largest pieces, then two more dropped, final one too
      for (k = 0; k < MAX_PIECES_DEF + 2; k++) send_piece('1, k == MAX_PIECES_DEF + 1);

      // random sets: sender idles lightly, then receiver lightly, then neither
      while (pieces_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if (pieces_sent < DIRECTED_ITEMS + RANDOM_ITEMS / 3) begin
            send_gap_pct = 7;
            stall_pct = 47;
         end else if (pieces_sent < DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct = 47;
            stall_pct = 7;
         end else begin
            send_gap_pct = 0;
            stall_pct = 0;
         end
         if ($urandom_range(0, 9) == 0) begin
            size = $urandom_range(MAX_PIECES_DEF + 1, MAX_PIECES_DEF + 6);
         end else if ($urandom_range(0, 9) < 3) begin
            size = $urandom_range(1, 4);
         end else begin
            size = $urandom_range(1, MAX_PIECES_DEF);
         end
         style = length_style_type'($urandom_range(0, 3));
         send_set(size, style);
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the block settle
      while (results_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d pieces in %0d sets, %0d of them past capacity, over three idle patterns",
               pieces_sent, sets_sent, overfilled_sets);
      $display("checked %0d merge cost results", results_checked);
      if (mismatch_count == 0 && results_waiting == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/omc_pkg.sv
hw/rtl/omc_datapath.sv
hw/rtl/omc_ctrl.sv
hw/rtl/optimal_merge_cost.sv
sim/optimal_merge_cost_checker.sv
sim/optimal_merge_cost_tb.sv
